/* hdl/sfs_pkg.sv */
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and constants of the sprite frame sequencer: item kinds,
// register indexes, table size, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sfs_pkg;

	// frame table size and derived widths
	localparam int MAX_FRAMES = 64;
	localparam int STEP_W     = $clog2(MAX_FRAMES);
	localparam int CMP_W      = 9;

	// fixed field widths
	localparam int FRAME_W = 8;
	localparam int COLS_W  = 8;
	localparam int DIM_W   = 11;
	localparam int DELAY_W = 8;
	localparam int LEN_W   = 7;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 3;
	localparam int POS_W   = 16;
	localparam int SRC_W   = 15;
	localparam int PROD_W  = FRAME_W + DIM_W;

	// divider: two quotient bits per cycle
	localparam int BITS_PER_STEP = 2;
	localparam int DIV_STEPS     = FRAME_W / BITS_PER_STEP;
	localparam int DCNT_W        = $clog2(DIV_STEPS);

	localparam logic [SRC_W-1:0] SAT_LIMIT = '1;

	// item kinds
	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_DRAW    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_COLUMNS  = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_FWIDTH   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_FHEIGHT  = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_DELAY    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_SEQLEN   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} sfs_state_t;

	typedef struct packed {
		logic in_ready;
		logic div_start;
		logic div_step;
		logic mul;
		logic load_out;
	} sfs_cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] in_kind;
		logic       out_free;
	} sfs_status_t;

endpackage

/* hdl/sfs_item_if.sv */
// ----------------------------------------------------------------------------
// sfs_item_if
// Input channel: load, draw and restart items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfs_item_if import sfs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [1:0]              kind;
	logic [5:0]              entry_index;
	logic [FRAME_W-1:0]      entry_frame;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic                    mirror;

	modport source (output valid, kind, entry_index, entry_frame, pos_x, pos_y, pos_z,
		mirror, input ready);
	modport sink (input valid, kind, entry_index, entry_frame, pos_x, pos_y, pos_z,
		mirror, output ready);
endinterface

/* hdl/sfs_result_if.sv */
// ----------------------------------------------------------------------------
// sfs_result_if
// Output channel: one draw result per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfs_result_if import sfs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [SRC_W-1:0]        source_x;
	logic [SRC_W-1:0]        source_y;
	logic [5:0]              step_now;
	logic                    first_step;
	logic signed [POS_W-1:0] dest_x;
	logic signed [POS_W-1:0] dest_y;
	logic signed [POS_W-1:0] dest_z;
	logic                    mirror_out;

	modport source (output valid, source_x, source_y, step_now, first_step, dest_x,
		dest_y, dest_z, mirror_out, input ready);
	modport sink (input valid, source_x, source_y, step_now, first_step, dest_x,
		dest_y, dest_z, mirror_out, output ready);
endinterface

/* hdl/sfs_ram.sv */
// ----------------------------------------------------------------------------
// sfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/sfs_ctrl.sv */
// ----------------------------------------------------------------------------
// sfs_ctrl
// Sequencer for one draw: fetch the table entry, run the divider, form
// the products, then hand the result to the output register.
// ----------------------------------------------------------------------------
module sfs_ctrl import sfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  sfs_status_t sts,
	output sfs_cmd_t    cmd
);

	sfs_state_t        state_q, state_d;
	logic [DCNT_W-1:0] div_cnt_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count divider cycles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_FETCH) begin
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid && sts.in_kind == KIND_DRAW) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:  cmd.in_ready  = 1'b1;
			ST_FETCH: cmd.div_start = 1'b1;
			ST_DIV:   cmd.div_step  = 1'b1;
			ST_MUL:   cmd.mul       = 1'b1;
			ST_DONE:  cmd.load_out  = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	// a draw always takes the fixed fetch/divide/multiply path
	a_draw_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && sts.in_valid && sts.in_kind == KIND_DRAW)
		|=> state_q == ST_FETCH)
		else $error("draw accepted without entering fetch");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> ##(DIV_STEPS + 1) state_q == ST_MUL)
		else $error("divider did not run its fixed step count");

endmodule

/* hdl/sfs_dp.sv */
// ----------------------------------------------------------------------------
// sfs_dp
// Datapath: configuration registers, step and delay counters, frame table,
// two-bit-per-cycle divider by columns, products and output register.
// ----------------------------------------------------------------------------
module sfs_dp import sfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  sfs_cmd_t          cmd,
	output sfs_status_t       sts,
	sfs_item_if.sink          items,
	sfs_result_if.source      results
);

	// configuration
	logic [COLS_W-1:0]  cols_q;
	logic [DIM_W-1:0]   fwidth_q;
	logic [DIM_W-1:0]   fheight_q;
	logic [DELAY_W-1:0] delay_q;
	logic [LEN_W-1:0]   seqlen_q;

	// sequencing state
	logic [STEP_W-1:0]  step_q;
	logic [DELAY_W-1:0] dcnt_q;

	// captured draw fields
	logic [STEP_W-1:0]       step_now_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic                    mirror_q;

	// divider and products
	logic [FRAME_W-1:0] rem_q, quo_q;
	logic [PROD_W-1:0]  prod_x_q, prod_y_q;

	// output register
	logic                    out_valid_q;
	logic [SRC_W-1:0]        src_x_q, src_y_q;
	logic [5:0]              out_step_q;
	logic                    out_first_q;
	logic signed [POS_W-1:0] out_x_q, out_y_q, out_z_q;
	logic                    out_mirror_q;

	logic               accept;
	logic               is_draw;
	logic               ram_we;
	logic [FRAME_W-1:0] ram_rdata;
	logic [COLS_W-1:0]  cols_eff;
	logic [CMP_W-1:0]   dsum;
	logic [CMP_W-1:0]   next_step;
	logic [CMP_W-1:0]   eff_len;
	logic [2*FRAME_W-1:0] div_next;

	// one divider cycle: BITS_PER_STEP restoring steps
	function automatic logic [2*FRAME_W-1:0] div_iter(
		input logic [FRAME_W-1:0] rem_in,
		input logic [FRAME_W-1:0] quo_in,
		input logic [COLS_W-1:0]  divisor
	);
		logic [FRAME_W-1:0] rem;
		logic [FRAME_W-1:0] quo;
		logic [FRAME_W:0]   trial;
		rem = rem_in;
		quo = quo_in;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			trial = {rem, quo[FRAME_W-1]};
			quo   = {quo[FRAME_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem    = FRAME_W'(trial - {1'b0, divisor});
				quo[0] = 1'b1;
			end else begin
				rem = trial[FRAME_W-1:0];
			end
		end
		return {rem, quo};
	endfunction

	assign accept   = items.valid && cmd.in_ready;
	assign is_draw  = items.kind == KIND_DRAW;
	assign ram_we   = accept && items.kind == KIND_LOAD
		&& CMP_W'(items.entry_index) < CMP_W'(MAX_FRAMES);
	assign cols_eff = (cols_q == '0) ? COLS_W'(1) : cols_q;
	assign div_next = div_iter(rem_q, quo_q, cols_eff);

	// effective sequence length and advance arithmetic
	always_comb begin
		eff_len = CMP_W'(seqlen_q);
		if (seqlen_q == '0) begin
			eff_len = CMP_W'(1);
		end else if (CMP_W'(seqlen_q) > CMP_W'(MAX_FRAMES)) begin
			eff_len = CMP_W'(MAX_FRAMES);
		end
		dsum      = CMP_W'(dcnt_q) + CMP_W'(1);
		next_step = CMP_W'(step_q) + CMP_W'(1);
	end

	assign sts.in_valid = items.valid;
	assign sts.in_kind  = items.kind;
	assign sts.out_free = !out_valid_q || results.ready;
	assign items.ready  = cmd.in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= COLS_W'(1);
			fwidth_q  <= '0;
			fheight_q <= '0;
			delay_q   <= '0;
			seqlen_q  <= LEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMNS: cols_q    <= cfg_data[COLS_W-1:0];
				CFG_FWIDTH:  fwidth_q  <= cfg_data[DIM_W-1:0];
				CFG_FHEIGHT: fheight_q <= cfg_data[DIM_W-1:0];
				CFG_DELAY:   delay_q   <= cfg_data[DELAY_W-1:0];
				CFG_SEQLEN:  seqlen_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// restart clears, draw advances step and delay counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			dcnt_q <= '0;
		end else if (accept && items.kind == KIND_RESTART) begin
			step_q <= '0;
			dcnt_q <= '0;
		end else if (accept && is_draw) begin
			if (dsum >= CMP_W'(delay_q)) begin
				step_q <= (next_step >= eff_len) ? '0 : STEP_W'(next_step);
				dcnt_q <= '0;
			end else begin
				dcnt_q <= dsum[DELAY_W-1:0];
			end
		end
	end

	// capture draw payload
	always_ff @(posedge clk) begin
		if (accept && is_draw) begin
			step_now_q <= step_q;
			pos_x_q    <= items.pos_x;
			pos_y_q    <= items.pos_y;
			pos_z_q    <= items.pos_z;
			mirror_q   <= items.mirror;
		end
	end

	sfs_ram #(
		.WIDTH(FRAME_W),
		.DEPTH(MAX_FRAMES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(STEP_W'(items.entry_index)),
		.wdata(items.entry_frame),
		.re   (accept && is_draw),
		.raddr(step_q),
		.rdata(ram_rdata)
	);

	// divide frame by columns, then scale both parts
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= ram_rdata;
		end else if (cmd.div_step) begin
			rem_q <= div_next[2*FRAME_W-1:FRAME_W];
			quo_q <= div_next[FRAME_W-1:0];
		end
		if (cmd.mul) begin
			prod_x_q <= PROD_W'(rem_q) * PROD_W'(fwidth_q);
			prod_y_q <= PROD_W'(quo_q) * PROD_W'(fheight_q);
		end
	end

	// output valid: set on load, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload, saturated origin
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			src_x_q      <= (prod_x_q > PROD_W'(SAT_LIMIT)) ? SAT_LIMIT
				: prod_x_q[SRC_W-1:0];
			src_y_q      <= (prod_y_q > PROD_W'(SAT_LIMIT)) ? SAT_LIMIT
				: prod_y_q[SRC_W-1:0];
			out_step_q   <= 6'(step_now_q);
			out_first_q  <= step_now_q == '0;
			out_x_q      <= pos_x_q;
			out_y_q      <= pos_y_q;
			out_z_q      <= pos_z_q;
			out_mirror_q <= mirror_q;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.source_x   = src_x_q;
	assign results.source_y   = src_y_q;
	assign results.step_now   = out_step_q;
	assign results.first_step = out_first_q;
	assign results.dest_x     = out_x_q;
	assign results.dest_y     = out_y_q;
	assign results.dest_z     = out_z_q;
	assign results.mirror_out = out_mirror_q;

	// remainder stays below the divisor through the division
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> rem_q < cols_eff)
		else $error("divider remainder not below column count");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(step_q) < CMP_W'(MAX_FRAMES))
		else $error("step index beyond frame table");

endmodule

/* hdl/sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// A draw passes table read, divider load, the two-bit-per-cycle divider,
// multiply and output load, which waits for a free output register; no
// item is taken until then. Load and restart items are taken one per
// cycle while idle and give no result. Asynchronous reset clears counters,
// configuration, control state and output valid; payload registers are
// not, and the frame table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit import sfs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	sfs_item_if.sink          items,
	sfs_result_if.source      results
);

	sfs_cmd_t    cmd;
	sfs_status_t sts;

	sfs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	sfs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.items    (items),
		.results  (results)
	);

endmodule

/* tb/sv/tb_sprite_frame_sequencer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer_unit
// Self-checking bench for the sprite frame sequencer. Load, draw, restart
// and unused items go in on the item channel. A local model of the frame
// table, step index and delay counter predicts one result per draw. Each
// result beat is compared field by field, in order, with the oldest
// prediction. Register settings change between phases, while the unit is
// idle. Both channels idle at random, and the result side holds off once
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer_unit import sfs_pkg::*; ();

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 200;
	localparam int TIMEOUT_NS   = 2_000_000;
	localparam int SAT_MAX      = 32767;

	typedef struct packed {
		logic [1:0]              kind;
		logic [5:0]              entry_index;
		logic [FRAME_W-1:0]      entry_frame;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic                    mirror;
	} sprite_item_t;

	typedef struct packed {
		logic [SRC_W-1:0]        source_x;
		logic [SRC_W-1:0]        source_y;
		logic [5:0]              step_now;
		logic                    first_step;
		logic signed [POS_W-1:0] dest_x;
		logic signed [POS_W-1:0] dest_y;
		logic signed [POS_W-1:0] dest_z;
		logic                    mirror_out;
	} draw_result_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sfs_item_if   item_bus ();
	sfs_result_if result_bus ();

	sprite_frame_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (item_bus),
		.results   (result_bus)
	);

	always #2 clk = ~clk;

	// sequencer model: registers, counters and frame table
	logic [COLS_W-1:0]  columns_reg   = 8'd1;
	logic [DIM_W-1:0]   fwidth_reg    = '0;
	logic [DIM_W-1:0]   fheight_reg   = '0;
	logic [DELAY_W-1:0] delay_reg     = '0;
	logic [LEN_W-1:0]   seqlen_reg    = 7'd1;
	logic [5:0]         cur_step      = '0;
	logic [DELAY_W-1:0] delay_cnt     = '0;
	logic [FRAME_W-1:0] frame_tab [MAX_FRAMES];

	draw_result_t pending_draws [$];
	int           mismatches   = 0;
	bit           sender_gaps     = 1'b1;
	bit           receiver_stalls = 1'b1;
	bit           hold_request    = 1'b0;
	int           stall_left      = 0;

	// Update the model with one accepted item; queue the draw result.
	task automatic apply_item(input sprite_item_t it);
		int unsigned  cols;
		int unsigned  frame;
		int unsigned  sx;
		int unsigned  sy;
		int unsigned  eff_len;
		int unsigned  nxt;
		logic [8:0]   cnt9;
		draw_result_t res;
		case (it.kind)
			KIND_LOAD: begin
				frame_tab[it.entry_index] = it.entry_frame;
			end
			KIND_RESTART: begin
				cur_step  = '0;
				delay_cnt = '0;
			end
			KIND_DRAW: begin
				cols  = (columns_reg == 0) ? 1 : columns_reg;
				frame = frame_tab[cur_step];
				sx    = (frame % cols) * fwidth_reg;
				sy    = (frame / cols) * fheight_reg;
				res.source_x   = SRC_W'((sx > SAT_MAX) ? SAT_MAX : sx);
				res.source_y   = SRC_W'((sy > SAT_MAX) ? SAT_MAX : sy);
				res.step_now   = cur_step;
				res.first_step = (cur_step == 0);
				res.dest_x     = it.pos_x;
				res.dest_y     = it.pos_y;
				res.dest_z     = it.pos_z;
				res.mirror_out = it.mirror;
				pending_draws = {pending_draws, res};
				// advance the step once the count reaches the delay
				cnt9 = delay_cnt + 9'd1;
				if (cnt9 >= delay_reg) begin
					eff_len = (seqlen_reg == 0) ? 1 :
						(seqlen_reg > MAX_FRAMES) ? MAX_FRAMES : seqlen_reg;
					nxt = cur_step + 1;
					if (nxt >= eff_len)
						nxt = 0;
					cur_step  = 6'(nxt);
					delay_cnt = '0;
				end else begin
					delay_cnt = cnt9[7:0];
				end
			end
			default: ;
		endcase
	endtask

	function automatic sprite_item_t make_item(input logic [1:0] kind,
		input int idx, input int frame, input int x,
		input int y, input int z, input int m);
		sprite_item_t it;
		it.kind        = kind;
		it.entry_index = 6'(idx);
		it.entry_frame = FRAME_W'(frame);
		it.pos_x       = POS_W'(x);
		it.pos_y       = POS_W'(y);
		it.pos_z       = POS_W'(z);
		it.mirror      = 1'(m);
		return it;
	endfunction

	function automatic sprite_item_t random_item(input int draw_share);
		sprite_item_t it;
		int unsigned  pick;
		it = make_item(KIND_DRAW, $urandom_range(0, 63), $urandom_range(0, 255),
			$urandom, $urandom, $urandom, $urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick >= draw_share) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				it.kind = KIND_LOAD;
			else if (pick < 82)
				it.kind = KIND_RESTART;
			else
				it.kind = KIND_UNUSED;
		end
		return it;
	endfunction

	// Offer one item, with an optional idle burst first; hold until accepted.
	task automatic send_item(input sprite_item_t it);
		if (sender_gaps && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_bus.valid       <= 1'b1;
		item_bus.kind        <= it.kind;
		item_bus.entry_index <= it.entry_index;
		item_bus.entry_frame <= it.entry_frame;
		item_bus.pos_x       <= it.pos_x;
		item_bus.pos_y       <= it.pos_y;
		item_bus.pos_z       <= it.pos_z;
		item_bus.mirror      <= it.mirror;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		apply_item(it);
	endtask

	// Drop valid, wait for all draws to come back, then let the unit go idle.
	task automatic settle();
		item_bus.valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all five registers on consecutive edges.
	task automatic program_regs(input logic [7:0] cols, input logic [10:0] fw,
		input logic [10:0] fh, input logic [7:0] dly, input logic [6:0] len);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_COLUMNS;
		cfg_data  <= cols;
		@(posedge clk);
		columns_reg = cols;
		cfg_index <= CFG_FWIDTH;
		cfg_data  <= fw;
		@(posedge clk);
		fwidth_reg = fw;
		cfg_index <= CFG_FHEIGHT;
		cfg_data  <= fh;
		@(posedge clk);
		fheight_reg = fh;
		cfg_index <= CFG_DELAY;
		cfg_data  <= dly;
		@(posedge clk);
		delay_reg = dly;
		cfg_index <= CFG_SEQLEN;
		cfg_data  <= len;
		@(posedge clk);
		seqlen_reg = len;
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [7:0]  cols;
		logic [10:0] fw;
		logic [10:0] fh;
		logic [7:0]  dly;
		logic [6:0]  len;
		case ($urandom_range(0, 5))
			0: cols = 8'd0;
			1: cols = 8'd1;
			2: cols = 8'd255;
			default: cols = 8'($urandom_range(2, 20));
		endcase
		case ($urandom_range(0, 5))
			0: fw = 11'd0;
			1: fw = 11'd2047;
			2: fw = 11'd1024;
			default: fw = 11'($urandom_range(1, 300));
		endcase
		case ($urandom_range(0, 5))
			0: fh = 11'd0;
			1: fh = 11'd2047;
			2: fh = 11'd1024;
			default: fh = 11'($urandom_range(1, 300));
		endcase
		case ($urandom_range(0, 7))
			0: dly = 8'd255;
			1: dly = 8'd0;
			2: dly = 8'd1;
			default: dly = 8'($urandom_range(0, 4));
		endcase
		case ($urandom_range(0, 7))
			0: len = 7'd0;
			1: len = 7'd127;
			2: len = 7'd64;
			3: len = 7'd1;
			default: len = 7'($urandom_range(2, 64));
		endcase
		program_regs(cols, fw, fh, dly, len);
	endtask

	// Reset settings: load step zero, then draw at the position extremes.
	task automatic test_reset_defaults();
		send_item(make_item(KIND_LOAD, 6'd0, 8'd255, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, 32767, -32768, -1, 1'b1));
		send_item(make_item(KIND_DRAW, 6'd63, 8'd255, -32768, 32767, 0, 1'b0));
	endtask

	// Fill every table slot so that any step can be drawn later on.
	task automatic test_table_fill();
		for (int i = 0; i < MAX_FRAMES; i++)
			send_item(make_item(KIND_LOAD, i, $urandom_range(0, 255), $urandom,
				$urandom, $urandom, $urandom_range(0, 1)));
	endtask

	// Zero columns, oversize length, saturation, unused kind and restart.
	task automatic test_extremes();
		settle();
		program_regs(8'd0, 11'd2047, 11'd2047, 8'd0, 7'd127);
		send_item(make_item(KIND_RESTART, 6'd0, 8'd0, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_LOAD, 6'd0, 8'd255, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_LOAD, 6'd1, 8'd0, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, 32767, 32767, 32767, 1'b1));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, -32768, -32768, -32768, 1'b0));
		send_item(make_item(KIND_UNUSED, 6'd63, 8'd255, -1, -1, -1, 1'b1));
		send_item(make_item(KIND_RESTART, 6'd0, 8'd0, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, 1, 2, 3, 1'b1));
		settle();
		// wide sheet, longest delay, zero length
		program_regs(8'd255, 11'd2047, 11'd2047, 8'd255, 7'd0);
		send_item(make_item(KIND_LOAD, 6'd0, 8'd254, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_RESTART, 6'd0, 8'd0, 0, 0, 0, 1'b0));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, 100, -100, 7, 1'b0));
		send_item(make_item(KIND_DRAW, 6'd0, 8'd0, -7, 100, -100, 1'b1));
	endtask

	// Advance to step three, then shorten the sequence below it.
	task automatic test_step_wrap();
		settle();
		program_regs(8'd16, 11'd100, 11'd50, 8'd1, 7'd64);
		send_item(make_item(KIND_RESTART, 6'd0, 8'd0, 0, 0, 0, 1'b0));
		repeat (3)
			send_item(random_item(100));
		settle();
		program_regs(8'd16, 11'd100, 11'd50, 8'd1, 7'd2);
		repeat (3)
			send_item(random_item(100));
	endtask

	// Hold the result side off while draws keep coming, so the input stalls.
	task automatic test_backpressure();
		bit saved_gaps;
		saved_gaps  = sender_gaps;
		sender_gaps = 1'b0;
		hold_request = 1'b1;
		repeat (40)
			send_item(random_item(100));
		sender_gaps = saved_gaps;
	endtask

	// Stop sending until every pending draw has come back, then resume.
	task automatic test_sender_pause();
		repeat (20)
			send_item(random_item(70));
		item_bus.valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (20)
			send_item(random_item(70));
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 10; p++) begin
			settle();
			random_config();
			repeat (110)
				send_item(random_item(62));
		end
	endtask

	// Last stretch runs with no idling on either side.
	task automatic test_unstalled_tail();
		settle();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		random_config();
		repeat (140)
			send_item(random_item(62));
	endtask

	// Result-side ready: random stall bursts and a long counted hold.
	initial begin
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (stall_left != 0) begin
				stall_left--;
				result_bus.ready <= 1'b0;
			end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			mismatches++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endtask

	// Compare each result beat with the oldest pending draw.
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_draws.size() == 0) begin
				mismatches++;
				$error("result beat with no draw pending");
			end else begin
				want = pending_draws.pop_front();
				check_field("source_x", want.source_x, result_bus.source_x);
				check_field("source_y", want.source_y, result_bus.source_y);
				check_field("step_now", want.step_now, result_bus.step_now);
				check_field("first_step", want.first_step, result_bus.first_step);
				check_field("dest_x", want.dest_x, result_bus.dest_x);
				check_field("dest_y", want.dest_y, result_bus.dest_y);
				check_field("dest_z", want.dest_z, result_bus.dest_z);
				check_field("mirror_out", want.mirror_out, result_bus.mirror_out);
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("sprite_frame_sequencer_unit verification failed");
		$finish;
	end

	initial begin
		int waited;
		item_bus.valid       <= 1'b0;
		item_bus.kind        <= KIND_LOAD;
		item_bus.entry_index <= '0;
		item_bus.entry_frame <= '0;
		item_bus.pos_x       <= '0;
		item_bus.pos_y       <= '0;
		item_bus.pos_z       <= '0;
		item_bus.mirror      <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_COLUMNS;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_table_fill();
		test_extremes();
		test_step_wrap();
		test_backpressure();
		test_sender_pause();
		test_random_phases();
		test_unstalled_tail();

		// drain with a bound, then let the pipeline go quiet
		item_bus.valid <= 1'b0;
		waited = 0;
		while (pending_draws.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_draws.size() != 0) begin
			mismatches++;
			$error("%0d draw results never arrived", pending_draws.size());
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("sprite_frame_sequencer_unit verification clean");
		else
			$display("sprite_frame_sequencer_unit verification failed");
		$finish;
	end

endmodule
